### src/pp_pkg.sv
`timescale 1ns / 1ps
package pp_pkg;

	localparam int FRAC_BITS_DEF = 16;
	// quotient bits kept: twice the rounded pixel range plus headroom
	localparam int Q_BITS = 19;

	localparam logic [2:0] REG_FOCAL_X  = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
	localparam logic [2:0] REG_CENTER_X = 3'd2;
	localparam logic [2:0] REG_CENTER_Y = 3'd3;
	localparam logic [2:0] REG_SKEW     = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEPTH = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               last_point;
	} pp_in_t;

	typedef struct packed {
		logic signed [15:0] pixel_col;
		logic signed [15:0] pixel_row;
		logic [1:0]         status;
		logic               last_out;
	} pp_out_t;

	typedef struct packed {
		logic [30:0]        focal_x;
		logic [30:0]        focal_y;
		logic [30:0]        center_x;
		logic [30:0]        center_y;
		logic signed [31:0] skew;
	} pp_cfg_t;

	typedef struct packed {
		logic bad;
		logic last;
		logic neg_u;
		logic neg_v;
		logic ovf_u;
		logic ovf_v;
	} pp_ctl_t;

endpackage

### src/pp_front.sv
`timescale 1ns / 1ps
module pp_front import pp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int RW = 67
) (
	input  logic            clk,
	input  logic            arst_n,
	input  pp_cfg_t         cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  pp_in_t          in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output pp_ctl_t         out_ctl,
	output logic [RW-1:0]   out_ru,
	output logic [RW-1:0]   out_rv,
	output logic [RW-1:0]   out_den
);

	logic                v_s1, v_s2, v_s3;
	logic                rdy1, rdy2, rdy3;
	logic signed [64:0]  pu0_s1, pu1_s1, pu2_s1, pv0_s1, pv1_s1;
	logic [30:0]         zm_s1, zm_s2;
	logic                bad_s1, bad_s2, last_s1, last_s2;
	logic signed [66:0]  nu_s2, nv_s2;
	logic [RW-1:0]       ru_s3, rv_s3, den_s3;
	pp_ctl_t             ctl_s3;
	logic [66:0]         mag_u, mag_v;
	logic                bad_in;

	assign rdy3 = !v_s3 || out_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	assign bad_in = in_data.point_z[31] || (in_data.point_z == 32'sd0);
	assign mag_u = nu_s2[66] ? 67'(-nu_s2) : 67'(nu_s2);
	assign mag_v = nv_s2[66] ? 67'(-nv_s2) : 67'(nv_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			pu0_s1  <= $signed({1'b0, cfg.focal_x}) * in_data.point_x;
			pu1_s1  <= cfg.skew * in_data.point_y;
			pu2_s1  <= $signed({1'b0, cfg.center_x}) * in_data.point_z;
			pv0_s1  <= $signed({1'b0, cfg.focal_y}) * in_data.point_y;
			pv1_s1  <= $signed({1'b0, cfg.center_y}) * in_data.point_z;
			zm_s1   <= in_data.point_z[30:0];
			bad_s1  <= bad_in;
			last_s1 <= in_data.last_point;
		end
		if (v_s1 && rdy2) begin
			nu_s2   <= {{2{pu0_s1[64]}}, pu0_s1} + {{2{pu1_s1[64]}}, pu1_s1}
				+ {{2{pu2_s1[64]}}, pu2_s1};
			nv_s2   <= {{2{pv0_s1[64]}}, pv0_s1} + {{2{pv1_s1[64]}}, pv1_s1};
			zm_s2   <= zm_s1;
			bad_s2  <= bad_s1;
			last_s2 <= last_s1;
		end
		if (v_s2 && rdy3) begin
			// remainder starts at twice the magnitude so the last bit gives rounding
			ru_s3        <= RW'({mag_u[65:0], 1'b0});
			rv_s3        <= RW'({mag_v[65:0], 1'b0});
			den_s3       <= RW'(zm_s2) << FRAC_BITS;
			ctl_s3.bad   <= bad_s2;
			ctl_s3.last  <= last_s2;
			ctl_s3.neg_u <= nu_s2[66];
			ctl_s3.neg_v <= nv_s2[66];
			ctl_s3.ovf_u <= 1'b0;
			ctl_s3.ovf_v <= 1'b0;
		end
	end

	assign out_valid = v_s3;
	assign out_ctl   = ctl_s3;
	assign out_ru    = ru_s3;
	assign out_rv    = rv_s3;
	assign out_den   = den_s3;

endmodule

### src/pp_div_step.sv
`timescale 1ns / 1ps
module pp_div_step import pp_pkg::*; #(
	parameter int RW = 67,
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pp_ctl_t           in_ctl,
	input  logic [RW-1:0]     in_ru,
	input  logic [RW-1:0]     in_rv,
	input  logic [RW-1:0]     in_den,
	input  logic [Q_BITS-1:0] in_tu,
	input  logic [Q_BITS-1:0] in_tv,
	output logic              out_valid,
	input  logic              out_ready,
	output pp_ctl_t           out_ctl,
	output logic [RW-1:0]     out_ru,
	output logic [RW-1:0]     out_rv,
	output logic [RW-1:0]     out_den,
	output logic [Q_BITS-1:0] out_tu,
	output logic [Q_BITS-1:0] out_tv
);

	logic              v_q;
	logic [RW-1:0]     dsh;
	logic              bu, bv;
	pp_ctl_t           ctl_n;
	logic [Q_BITS-1:0] tu_n, tv_n;

	assign in_ready = !v_q || out_ready;
	assign dsh = in_den << SHIFT;
	assign bu  = in_ru >= dsh;
	assign bv  = in_rv >= dsh;

	always_comb begin
		ctl_n = in_ctl;
		tu_n  = in_tu;
		tv_n  = in_tv;
		// top step only flags a quotient too large for the pixel range
		if (SHIFT == Q_BITS) begin
			ctl_n.ovf_u = in_ctl.ovf_u | bu;
			ctl_n.ovf_v = in_ctl.ovf_v | bv;
		end else begin
			tu_n = {in_tu[Q_BITS-2:0], bu};
			tv_n = {in_tv[Q_BITS-2:0], bv};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			out_ctl <= ctl_n;
			out_ru  <= bu ? in_ru - dsh : in_ru;
			out_rv  <= bv ? in_rv - dsh : in_rv;
			out_den <= in_den;
			out_tu  <= tu_n;
			out_tv  <= tv_n;
		end
	end

	assign out_valid = v_q;

endmodule

### src/pp_back.sv
`timescale 1ns / 1ps
module pp_back import pp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pp_ctl_t           in_ctl,
	input  logic [Q_BITS-1:0] in_tu,
	input  logic [Q_BITS-1:0] in_tv,
	output logic              out_valid,
	input  logic              out_ready,
	output pp_out_t           out_data
);

	logic    v_q;
	pp_out_t res_q, res_n;
	logic    sat_u, sat_v;
	logic [15:0] col, row;

	function automatic logic [16:0] round_sat(input logic [Q_BITS-1:0] t,
		input logic neg, input logic ovf);
		logic [Q_BITS-1:0] q;
		logic [15:0]       val;
		logic              sat;
		q   = Q_BITS'(({1'b0, t} + {{Q_BITS{1'b0}}, 1'b1}) >> 1);
		sat = ovf;
		if (neg) begin
			if (ovf || q > Q_BITS'(32768)) begin
				sat = 1'b1;
				val = 16'h8000;
			end else begin
				val = 16'(-q);
			end
		end else begin
			if (ovf || q > Q_BITS'(32767)) begin
				sat = 1'b1;
				val = 16'h7fff;
			end else begin
				val = q[15:0];
			end
		end
		return {sat, val};
	endfunction

	assign {sat_u, col} = round_sat(in_tu, in_ctl.neg_u, in_ctl.ovf_u);
	assign {sat_v, row} = round_sat(in_tv, in_ctl.neg_v, in_ctl.ovf_v);

	always_comb begin
		res_n.last_out = in_ctl.last;
		if (in_ctl.bad) begin
			res_n.pixel_col = '0;
			res_n.pixel_row = '0;
			res_n.status    = ST_DEPTH;
		end else begin
			res_n.pixel_col = col;
			res_n.pixel_row = row;
			res_n.status    = (sat_u || sat_v) ? ST_SAT : ST_OK;
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (in_ready) v_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) res_q <= res_n;
	end

	assign out_valid = v_q;
	assign out_data  = res_q;

endmodule

### src/pinhole_projection_top.sv
`timescale 1ns / 1ps
// Pipeline: 3 multiply/sum stages, 20 restoring divide stages (the top one only flags
// overflow, the other 19 give one quotient bit each) and 1 output register.
// Throughput: one item per cycle while out_ready is high; under stall every stage
// holds its own item.
// Reset (arst_n low, asynchronous) clears all valid bits and sets registers to
// focal 1.0, center 0, skew 0.
module pinhole_projection_top import pp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  pp_in_t      in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pp_out_t     out_data
);

	localparam int RW = (50 + FRAC_BITS > 67) ? 50 + FRAC_BITS : 67;
	localparam int NS = Q_BITS + 1;

	pp_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focal_x  <= 31'(65536);
			cfg_q.focal_y  <= 31'(65536);
			cfg_q.center_x <= '0;
			cfg_q.center_y <= '0;
			cfg_q.skew     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FOCAL_X:  cfg_q.focal_x  <= cfg_data[30:0];
				REG_FOCAL_Y:  cfg_q.focal_y  <= cfg_data[30:0];
				REG_CENTER_X: cfg_q.center_x <= cfg_data[30:0];
				REG_CENTER_Y: cfg_q.center_y <= cfg_data[30:0];
				REG_SKEW:     cfg_q.skew     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic              v_c   [0:NS];
	logic              rdy_c [0:NS];
	pp_ctl_t           ctl_c [0:NS];
	logic [RW-1:0]     ru_c  [0:NS];
	logic [RW-1:0]     rv_c  [0:NS];
	logic [RW-1:0]     den_c [0:NS];
	logic [Q_BITS-1:0] tu_c  [0:NS];
	logic [Q_BITS-1:0] tv_c  [0:NS];

	pp_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(v_c[0]), .out_ready(rdy_c[0]), .out_ctl(ctl_c[0]),
		.out_ru(ru_c[0]), .out_rv(rv_c[0]), .out_den(den_c[0])
	);

	assign tu_c[0] = '0;
	assign tv_c[0] = '0;

	for (genvar i = 0; i < NS; i++) begin : g_div
		pp_div_step #(.RW(RW), .SHIFT(Q_BITS - i)) u_step (
			.clk(clk), .arst_n(arst_n),
			.in_valid(v_c[i]), .in_ready(rdy_c[i]), .in_ctl(ctl_c[i]),
			.in_ru(ru_c[i]), .in_rv(rv_c[i]), .in_den(den_c[i]),
			.in_tu(tu_c[i]), .in_tv(tv_c[i]),
			.out_valid(v_c[i+1]), .out_ready(rdy_c[i+1]), .out_ctl(ctl_c[i+1]),
			.out_ru(ru_c[i+1]), .out_rv(rv_c[i+1]), .out_den(den_c[i+1]),
			.out_tu(tu_c[i+1]), .out_tv(tv_c[i+1])
		);
	end

	pp_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_c[NS]), .in_ready(rdy_c[NS]), .in_ctl(ctl_c[NS]),
		.in_tu(tu_c[NS]), .in_tv(tv_c[NS]),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

### tb/pp_checker.sv
`timescale 1ns / 1ps
module pp_checker import pp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  pp_in_t      in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  pp_out_t     out_data,
	output int          errors,
	output int          pending
);

	pp_cfg_t intrinsics;
	pp_out_t pixel_q[$];

	// round num/den half away from zero, clamp to 16 bits
	function automatic logic [15:0] round_pixel(input logic signed [95:0] num,
			input logic [63:0] den, inout logic sat);
		logic [95:0] mag;
		logic [95:0] q;
		logic [95:0] r;
		logic neg;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / den;
		r = mag % den;
		if (r * 2 >= den)
			q = q + 1;
		if (neg) begin
			if (q > 32768) begin
				sat = 1'b1;
				q = 32768;
			end
			return 16'(-q);
		end
		if (q > 32767) begin
			sat = 1'b1;
			q = 32767;
		end
		return q[15:0];
	endfunction

	function automatic pp_out_t project_point(input pp_in_t p);
		pp_out_t o;
		logic signed [95:0] un;
		logic signed [95:0] vn;
		logic [63:0] den;
		logic sat;
		o = '0;
		sat = 1'b0;
		o.last_out = p.last_point;
		if (p.point_z <= 0) begin
			o.status = ST_DEPTH;
			return o;
		end
		den = 64'(p.point_z) << 16;
		un = $signed({65'd0, intrinsics.focal_x}) * 96'(p.point_x)
			+ 96'(intrinsics.skew) * 96'(p.point_y)
			+ $signed({65'd0, intrinsics.center_x}) * 96'(p.point_z);
		vn = $signed({65'd0, intrinsics.focal_y}) * 96'(p.point_y)
			+ $signed({65'd0, intrinsics.center_y}) * 96'(p.point_z);
		o.pixel_col = round_pixel(un, den, sat);
		o.pixel_row = round_pixel(vn, den, sat);
		o.status = sat ? ST_SAT : ST_OK;
		return o;
	endfunction

	assign pending = pixel_q.size();

	always @(posedge clk or negedge arst_n) begin
		pp_out_t exp_px;
		if (!arst_n) begin
			intrinsics.focal_x <= 31'd65536;
			intrinsics.focal_y <= 31'd65536;
			intrinsics.center_x <= '0;
			intrinsics.center_y <= '0;
			intrinsics.skew <= '0;
			errors <= 0;
			pixel_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FOCAL_X: intrinsics.focal_x <= cfg_data[30:0];
					REG_FOCAL_Y: intrinsics.focal_y <= cfg_data[30:0];
					REG_CENTER_X: intrinsics.center_x <= cfg_data[30:0];
					REG_CENTER_Y: intrinsics.center_y <= cfg_data[30:0];
					REG_SKEW: intrinsics.skew <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pixel_q.push_back(project_point(in_data));
			if (out_valid && out_ready) begin
				if (pixel_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result %p", out_data);
					errors <= errors + 1;
				end else begin
					exp_px = pixel_q.pop_front();
					if (exp_px !== out_data) begin
						if (errors < 10)
							$display("mismatch: expected %p got %p", exp_px, out_data);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import pp_pkg::*;

	localparam int LATENCY = 24;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pp_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pp_out_t out_data;
	int errors;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	pinhole_projection_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	pp_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data), .errors(errors), .pending(pending)
	);

	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// valid stays high after the item so the next one can follow without a gap
	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{point_x: x, point_y: y, point_z: z, last_point: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// mostly modest coordinates and positive depth, some full range
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
			default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21)) <<< 6;
		endcase
	endfunction

	function automatic logic [31:0] rand_depth();
		case ($urandom_range(7))
			0: return $urandom;
			1: return 32'($urandom_range(3));
			2: return 32'($signed(-$urandom_range(5)));
			default: return 32'($urandom_range(32'h7fff_ffff, 1));
		endcase
	endfunction

	task automatic set_intrinsics(input int mode);
		case (mode)
			0: begin
				write_reg(REG_FOCAL_X, 32'h7fff_ffff);
				write_reg(REG_FOCAL_Y, 32'h7fff_ffff);
				write_reg(REG_CENTER_X, 32'h7fff_ffff);
				write_reg(REG_CENTER_Y, 32'h7fff_ffff);
				write_reg(REG_SKEW, 32'h8000_0000);
			end
			1: begin
				write_reg(REG_FOCAL_X, 32'h0);
				write_reg(REG_FOCAL_Y, 32'hffff_ffff);
				write_reg(REG_CENTER_X, 32'h0);
				write_reg(REG_CENTER_Y, 32'h0);
				write_reg(REG_SKEW, 32'h7fff_ffff);
			end
			default: begin
				write_reg(REG_FOCAL_X, $urandom_range(1000 << 16));
				write_reg(REG_FOCAL_Y, $urandom_range(1000 << 16));
				write_reg(REG_CENTER_X, $urandom_range(640 << 16));
				write_reg(REG_CENTER_Y, $urandom_range(480 << 16));
				write_reg(REG_SKEW, 32'($signed($urandom_range(1 << 18)) - (1 << 17)));
				write_reg(3'd7, $urandom);
			end
		endcase
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: field extremes, depth edges, rounding ties, saturation
		send_point(32'h0, 32'h0, 32'h0001_0000, 1'b0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b1);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		send_point(32'h1, 32'h1, 32'h0, 1'b0);
		send_point(32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000, 1'b1);
		send_point(32'h0, 32'h0, 32'hffff_ffff, 1'b0);
		send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 1'b0);
		send_point(32'h0001_8000, 32'hfffe_8000, 32'h0001_0000, 1'b1);
		send_point(32'h7fff_0000, 32'h8000_0000, 32'h0001_0000, 1'b0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1'b0);
		drain_pipe();
		set_intrinsics(0);
		send_point(32'h0001_0000, 32'hffff_0000, 32'h0001_0000, 1'b0);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
		send_point(32'h0, 32'h0, 32'h7fff_ffff, 1'b0);
		drain_pipe();
		set_intrinsics(1);
		send_point(32'h1234_5678, 32'h0000_0001, 32'h7fff_ffff, 1'b0);
		send_point(32'h0, 32'h8000_0000, 32'h0001_0000, 1'b1);
		drain_pipe();

		for (int phase = 0; phase < 8; phase++) begin
			set_intrinsics(phase == 7 ? 0 : 2);
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 9; recv_stall_pct = 9; end
			endcase
			for (int n = 0; n < 125; n++) begin
				if (n == 60) begin
					in_valid <= 1'b0;
					while (pending != 0)
						@(negedge clk);
				end
				send_point(rand_coord(), rand_coord(), rand_depth(), 1'($urandom));
			end
			drain_pipe();
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
